### sv/segment_circle_clearance_test_macros.svh
// Assertion helpers used by the clearance test RTL.
`ifndef SEGMENT_CIRCLE_CLEARANCE_TEST_MACROS_SVH
`define SEGMENT_CIRCLE_CLEARANCE_TEST_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define SCCT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("clearance test assertion failed");

// Next-cycle implication, sampled on clk and switched off during reset.
`define SCCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("clearance test assertion failed");

`endif

### sv/scct_pkg.sv
package scct_pkg;

  // Fraction bits of the projection parameter.
  localparam int FRAC_BITS = 16;
  localparam int T_W = FRAC_BITS + 1;
  localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_BITS;

  localparam int DIST_W = 33;
  localparam int RADIUS_W = 32;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Clamping decision for the projection parameter.
  typedef struct packed {
    logic le0;  // dot product is zero or negative
    logic ge;   // dot product reaches the squared length
  } scct_mode_t;

endpackage

### sv/segment_circle_clearance_test.sv
// Throughput: one item per cycle; the pipeline only holds when a finished result
//   is waiting and out_stall is high.
// Reset (synchronous, active high) clears every stage valid bit; data registers are not reset.
module segment_circle_clearance_test #(
  parameter int COORD_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] point_x,
  input  logic [31:0] point_y,
  input  logic [31:0] seg_start_x,
  input  logic [31:0] seg_start_y,
  input  logic [31:0] seg_end_x,
  input  logic [31:0] seg_end_y,
  input  logic [31:0] clear_radius,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [32:0] distance,
  output logic        intersects
);

`include "segment_circle_clearance_test_macros.svh"

  localparam int CW = COORD_WIDTH;
  localparam int RW = scct_pkg::RADIUS_W;
  localparam int SQ = CW + 2;
  localparam int DIV_SIDE_W = 4 * (CW + 1) + RW;
  localparam int CMP_W = SQ + scct_pkg::DIST_W;

  // The whole pipeline moves as one; it holds only while the output register
  // has a result that the receiver has not taken yet.
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Coordinates are the low COORD_WIDTH bits of the zero-extended field.
  function automatic logic signed [CW:0] coord(input logic [31:0] raw);
    logic [63:0] ext;
    logic [CW-1:0] c;
    ext = {32'b0, raw};
    c = ext[CW-1:0];
    return $signed({c[CW-1], c});
  endfunction

  // Stage A: segment direction V = E - S and point offset W = P - S.
  logic                a_vld;
  logic signed [CW:0]  a_vx, a_vy, a_wx, a_wy;
  logic [RW-1:0]       a_rad;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_vx  <= coord(seg_end_x) - coord(seg_start_x);
      a_vy  <= coord(seg_end_y) - coord(seg_start_y);
      a_wx  <= coord(point_x) - coord(seg_start_x);
      a_wy  <= coord(point_y) - coord(seg_start_y);
      a_rad <= clear_radius;
    end
  end

  // Stage B: the four products of the squared length and the dot product.
  logic                      b_vld;
  logic signed [2*CW+1:0]    b_vxx, b_vyy, b_dx, b_dy;
  logic signed [CW:0]        b_vx, b_vy, b_wx, b_wy;
  logic [RW-1:0]             b_rad;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (adv) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_vxx <= a_vx * a_vx;
      b_vyy <= a_vy * a_vy;
      b_dx  <= a_wx * a_vx;
      b_dy  <= a_wy * a_vy;
      b_vx  <= a_vx;
      b_vy  <= a_vy;
      b_wx  <= a_wx;
      b_wy  <= a_wy;
      b_rad <= a_rad;
    end
  end

  // Stage C: v2 = |V|^2 and dot = W.V, both exact.
  logic                      c_vld;
  logic [2*CW+1:0]           c_v2;
  logic signed [2*CW+2:0]    c_dot;
  logic [DIV_SIDE_W-1:0]     c_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (adv) begin
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_v2   <= (2*CW+2)'(b_vxx) + (2*CW+2)'(b_vyy);
      c_dot  <= (2*CW+3)'(b_dx) + (2*CW+3)'(b_dy);
      c_side <= {b_vx, b_vy, b_wx, b_wy, b_rad};
    end
  end

  // Projection parameter t = clamp(dot / v2) with 16 fraction bits. A
  // zero-length segment has dot equal to zero, so t is zero and the
  // residual below is simply W.
  logic                       d_vld;
  logic [scct_pkg::T_W-1:0]   d_t;
  logic [DIV_SIDE_W-1:0]      d_side;

  scct_div #(
    .CW     (CW),
    .SIDE_W (DIV_SIDE_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (c_vld),
    .v2       (c_v2),
    .dot      (c_dot),
    .side_in  (c_side),
    .out_vld  (d_vld),
    .t        (d_t),
    .side_out (d_side)
  );

  logic signed [CW:0] d_vx, d_vy, d_wx, d_wy;
  logic [RW-1:0]      d_rad;
  assign {d_vx, d_vy, d_wx, d_wy, d_rad} = d_side;

  // Stage E: offset along each axis, floor(t * V / 2^16), by arithmetic shift.
  logic                       e_vld;
  logic signed [CW+1:0]       e_ox, e_oy;
  logic signed [CW:0]         e_wx, e_wy;
  logic [RW-1:0]              e_rad;
  logic signed [CW+scct_pkg::T_W+1:0] e_px, e_py;

  always_comb begin
    e_px = $signed({1'b0, d_t}) * d_vx;
    e_py = $signed({1'b0, d_t}) * d_vy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (adv) begin
      e_vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_ox  <= (CW+2)'(e_px >>> scct_pkg::FRAC_BITS);
      e_oy  <= (CW+2)'(e_py >>> scct_pkg::FRAC_BITS);
      e_wx  <= d_wx;
      e_wy  <= d_wy;
      e_rad <= d_rad;
    end
  end

  // Stage F: residual R = W - O.
  logic                 f_vld;
  logic signed [CW+1:0] f_rx, f_ry;
  logic [RW-1:0]        f_rad;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (adv) begin
      f_vld <= e_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_rx  <= (CW+2)'(e_wx) - e_ox;
      f_ry  <= (CW+2)'(e_wy) - e_oy;
      f_rad <= e_rad;
    end
  end

  // Stage G: squares of the residual.
  logic                 g_vld;
  logic signed [2*CW+3:0] g_sx, g_sy;
  logic [RW-1:0]        g_rad;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld <= 1'b0;
    end else if (adv) begin
      g_vld <= f_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_sx  <= f_rx * f_rx;
      g_sy  <= f_ry * f_ry;
      g_rad <= f_rad;
    end
  end

  // Stage H: squared distance. Each square is below 2^(2CW+2), so the sum fits.
  logic               h_vld;
  logic [2*CW+3:0]    h_d2;
  logic [RW-1:0]      h_rad;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_vld <= 1'b0;
    end else if (adv) begin
      h_vld <= g_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h_d2  <= g_sx + g_sy;
      h_rad <= g_rad;
    end
  end

  // Floored square root, one result bit per stage.
  logic            s_vld;
  logic [SQ-1:0]   s_root;
  logic [RW-1:0]   s_rad;

  scct_sqrt #(
    .CW     (CW),
    .SIDE_W (RW)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (h_vld),
    .n        (h_d2),
    .side_in  (h_rad),
    .out_vld  (s_vld),
    .root     (s_root),
    .side_out (s_rad)
  );

  // Output register: saturate the distance and compare it with the radius.
  logic [CMP_W-1:0] s_root_w;
  logic [RW-1:0]    o_rad;
  logic             s_sat;

  always_comb begin
    s_root_w = CMP_W'(s_root);
    s_sat    = (s_root_w > CMP_W'(scct_pkg::DIST_MAX));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      distance   <= s_sat ? scct_pkg::DIST_MAX : s_root_w[scct_pkg::DIST_W-1:0];
      intersects <= (s_root_w <= CMP_W'(s_rad));
      o_rad      <= s_rad;
    end
  end

  // A set flag means the reported distance lies within the radius it carried.
  `SCCT_ASSERT_IMPL(a_flag_radius, out_valid && intersects, 33'(o_rad) >= distance)
  // A held pipeline keeps its last square-root stage unchanged.
  `SCCT_ASSERT_NEXT(a_hold_sqrt, !adv, $stable(s_vld) && $stable(s_root))
  // The input side only stalls while a result waits at the output.
  `SCCT_ASSERT_IMPL(a_stall_cause, in_stall, out_valid && out_stall)

endmodule

### sv/scct_div.sv
module scct_div #(
  parameter int CW = 32,
  parameter int SIDE_W = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_vld,
  input  logic [2*CW+1:0]             v2,
  input  logic signed [2*CW+2:0]      dot,
  input  logic [SIDE_W-1:0]           side_in,
  output logic                        out_vld,
  output logic [scct_pkg::T_W-1:0]    t,
  output logic [SIDE_W-1:0]           side_out
);

  localparam int RW = 2 * CW + 3;
  localparam int NS = scct_pkg::FRAC_BITS;

  logic                           vld  [0:NS];
  logic [RW-1:0]                  rem  [0:NS];
  logic [2*CW+1:0]                den  [0:NS];
  logic [NS-1:0]                  quo  [0:NS];
  scct_pkg::scct_mode_t           mode [0:NS];
  logic [SIDE_W-1:0]              side [0:NS];

  // Entry stage: decide the clamp and load the remainder.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0]      <= dot[RW-1:0];
      den[0]      <= v2;
      quo[0]      <= '0;
      mode[0].le0 <= (dot <= 0);
      mode[0].ge  <= (dot >= $signed({1'b0, v2}));
      side[0]     <= side_in;
    end
  end

  // One restoring quotient bit per stage.
  for (genvar i = 1; i <= NS; i++) begin : g_step
    logic [RW:0] sh;
    logic        take;

    always_comb begin
      sh   = {rem[i-1], 1'b0};
      take = (sh >= {2'b0, den[i-1]});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (adv) begin
        vld[i] <= vld[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[i]  <= take ? RW'(sh - {2'b0, den[i-1]}) : sh[RW-1:0];
        den[i]  <= den[i-1];
        quo[i]  <= {quo[i-1][NS-2:0], take};
        mode[i] <= mode[i-1];
        side[i] <= side[i-1];
      end
    end
  end

  always_comb begin
    out_vld  = vld[NS];
    side_out = side[NS];
    if (mode[NS].le0) begin
      t = '0;
    end else if (mode[NS].ge) begin
      t = scct_pkg::T_ONE;
    end else begin
      t = {1'b0, quo[NS]};
    end
  end

endmodule

### sv/scct_sqrt.sv
module scct_sqrt #(
  parameter int CW = 32,
  parameter int SIDE_W = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_vld,
  input  logic [2*CW+3:0]       n,
  input  logic [SIDE_W-1:0]     side_in,
  output logic                  out_vld,
  output logic [CW+1:0]         root,
  output logic [SIDE_W-1:0]     side_out
);

  localparam int SQ = CW + 2;
  localparam int NW = 2 * SQ;

  logic              vld  [0:SQ];
  logic [NW-1:0]     rad  [0:SQ];
  logic [SQ+1:0]     rem  [0:SQ];
  logic [SQ-1:0]     rt   [0:SQ];
  logic [SIDE_W-1:0] side [0:SQ];

  always_comb begin
    vld[0]  = in_vld;
    rad[0]  = n;
    rem[0]  = '0;
    rt[0]   = '0;
    side[0] = side_in;
  end

  // One root bit per stage, two radicand bits brought down each time.
  for (genvar i = 1; i <= SQ; i++) begin : g_step
    logic [SQ+3:0] rr;
    logic [SQ+3:0] trial;
    logic          take;

    always_comb begin
      rr    = {rem[i-1], rad[i-1][NW-1:NW-2]};
      trial = {2'b0, rt[i-1], 2'b01};
      take  = (rr >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (adv) begin
        vld[i] <= vld[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rad[i]  <= {rad[i-1][NW-3:0], 2'b00};
        rem[i]  <= take ? (SQ+2)'(rr - trial) : rr[SQ+1:0];
        rt[i]   <= {rt[i-1][SQ-2:0], take};
        side[i] <= side[i-1];
      end
    end
  end

  always_comb begin
    out_vld  = vld[SQ];
    root     = rt[SQ];
    side_out = side[SQ];
  end

endmodule

### tb/tb.sv
module tb;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] point_x, point_y, seg_start_x, seg_start_y, seg_end_x, seg_end_y;
  logic [31:0] clear_radius;
  logic        out_valid;
  logic        out_stall;
  logic [32:0] distance;
  logic        intersects;

  segment_circle_clearance_test u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .point_x(point_x), .point_y(point_y),
    .seg_start_x(seg_start_x), .seg_start_y(seg_start_y),
    .seg_end_x(seg_end_x), .seg_end_y(seg_end_y),
    .clear_radius(clear_radius),
    .out_valid(out_valid), .out_stall(out_stall),
    .distance(distance), .intersects(intersects)
  );

  // One query: circle centre, segment ends and clearance radius.
  typedef struct {
    logic [31:0] px, py, sx, sy, ex, ey, rad;
  } query_t;

  // One clearance answer.
  typedef struct {
    logic [scct_pkg::DIST_W-1:0] dlen;
    logic                        hit;
  } answer_t;

  // One row of the directed table; known rows carry a typed-in answer.
  typedef struct {
    query_t                      q;
    logic                        known;
    logic [scct_pkg::DIST_W-1:0] dlen;
    logic                        hit;
  } dir_row_t;

  dir_row_t dir_rows [14] = '{
    // All zero: distance zero, touching with zero radius.
    '{'{0, 0, 0, 0, 0, 0, 0}, 1'b1, 33'd0, 1'b1},
    // Zero-length segment, 3-4-5 triangle in raw units.
    '{'{3, 4, 0, 0, 0, 0, 4}, 1'b1, 33'd5, 1'b0},
    '{'{3, 4, 0, 0, 0, 0, 5}, 1'b1, 33'd5, 1'b1},
    // Centre beside the middle of a horizontal segment.
    '{'{50, 7, 0, 0, 100, 0, 7}, 1'b1, 33'd7, 1'b1},
    // Projection before the first end clamps to it.
    '{'{-30, 40, 0, 0, 100, 0, 49}, 1'b1, 33'd50, 1'b0},
    // Projection past the second end clamps to it.
    '{'{130, -40, 0, 0, 100, 0, 50}, 1'b1, 33'd50, 1'b1},
    // Opposite corners of the coordinate range, zero-length segment.
    '{'{32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
        32'h8000_0000, 32'h8000_0000, 32'hffff_ffff}, 1'b1, 33'd6074000998, 1'b0},
    // Maximum radius always covers a single-axis extreme distance.
    '{'{32'h7fff_ffff, 0, 32'h8000_0000, 0, 32'h8000_0000, 0,
        32'hffff_ffff}, 1'b1, 33'h0_ffff_ffff, 1'b1},
    // Rows checked against the predictor only.
    '{'{32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
        32'h7fff_ffff, 32'h8000_0000, 32'h0}, 1'b0, 33'd0, 1'b0},
    '{'{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
        32'h8000_0000, 32'h7fff_ffff, 32'haaaa_aaaa}, 1'b0, 33'd0, 1'b0},
    '{'{32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001,
        32'h7fff_ffff, 32'hffff_ffff, 32'h5555_5555}, 1'b0, 33'd0, 1'b0},
    '{'{1, 1, 0, 0, 3, 7, 1}, 1'b0, 33'd0, 1'b0},
    '{'{-5, 9, 2, -3, -11, 17, 3}, 1'b0, 33'd0, 1'b0},
    '{'{77, 77, -100, -100, 100, 100, 0}, 1'b0, 33'd0, 1'b0}
  };

  answer_t pending_answers[$];
  int      mismatch_count = 0;
  int      answers_seen = 0;
  int      queries_sent = 0;
  bit      hold_off_done = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // The run is bounded by a generous wall; with under 2000 items, random gaps
  // and stalls, a correct run needs far less.
  initial begin
    #4000000;
    $display("tb NOT OK");
    $finish;
  end

  // Floored integer square root of a nonnegative value up to 132 bits.
  function automatic logic [65:0] isqrt_floor(logic [131:0] n);
    logic [131:0] res, bitv, trial;
    res = 0;
    bitv = 132'd1 << 130;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      trial = res + bitv;
      if (n >= trial) begin
        n = n - trial;
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[65:0];
  endfunction

  // Predicts the distance from the circle centre to the segment and the hit flag.
  function automatic answer_t predict_clearance(query_t q);
    logic signed [35:0]  vx, vy, wx, wy, rx, ry;
    logic signed [35:0]  ox, oy;
    logic signed [75:0]  v2, dot, rem;
    logic signed [131:0] d2;
    logic [scct_pkg::T_W-1:0] t;
    logic signed [55:0]  px_t, py_t;
    logic [65:0]         d;
    answer_t             a;
    vx = $signed(q.ex) - $signed(q.sx);
    vy = $signed(q.ey) - $signed(q.sy);
    wx = $signed(q.px) - $signed(q.sx);
    wy = $signed(q.py) - $signed(q.sy);
    rx = wx;
    ry = wy;
    v2 = vx * vx + vy * vy;
    if (v2 != 0) begin
      dot = wx * vx + wy * vy;
      if (dot <= 0) begin
        t = 0;
      end else if (dot >= v2) begin
        t = scct_pkg::T_ONE;
      end else begin
        rem = dot;
        t = 0;
        for (int i = 0; i < scct_pkg::FRAC_BITS; i++) begin
          rem = rem <<< 1;
          t = t << 1;
          if (rem >= v2) begin
            rem = rem - v2;
            t[0] = 1'b1;
          end
        end
      end
      // Arithmetic shift gives floor toward minus infinity.
      px_t = $signed({1'b0, t}) * vx;
      py_t = $signed({1'b0, t}) * vy;
      ox = 36'(px_t >>> scct_pkg::FRAC_BITS);
      oy = 36'(py_t >>> scct_pkg::FRAC_BITS);
      rx = wx - ox;
      ry = wy - oy;
    end
    d2 = rx * rx + ry * ry;
    d = isqrt_floor(132'(d2));
    a.dlen = (d > 66'(scct_pkg::DIST_MAX)) ? scct_pkg::DIST_MAX : d[scct_pkg::DIST_W-1:0];
    a.hit = (d <= 66'(q.rad));
    return a;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on answer %0d: %s got %0h want %0h", answers_seen, what, got, want);
    mismatch_count++;
  endtask

  // Drives one query and waits for its transfer; bursts come from the caller.
  task automatic send_query(query_t q);
    answer_t p;
    in_valid <= 1'b1;
    point_x <= q.px; point_y <= q.py;
    seg_start_x <= q.sx; seg_start_y <= q.sy;
    seg_end_x <= q.ex; seg_end_y <= q.ey;
    clear_radius <= q.rad;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = predict_clearance(q);
    pending_answers = {pending_answers, p};
    queries_sent++;
  endtask

  // Checks the typed-in answer of a directed row against the predictor.
  task automatic check_typed(dir_row_t r);
    answer_t p;
    p = predict_clearance(r.q);
    if (p.dlen !== r.dlen) report_mismatch("typed-in distance", 64'(p.dlen), 64'(r.dlen));
    if (p.hit !== r.hit) report_mismatch("typed-in flag", 64'(p.hit), 64'(r.hit));
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'(int'($urandom_range(0, 400)) - 200);
      2: return $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 3)
                                     : 32'h8000_0000 + $urandom_range(0, 3);
      3: return 32'($signed($urandom) >>> $urandom_range(4, 28));
      default: return 32'(int'($urandom_range(0, 65535)) - 32768);
    endcase
  endfunction

  // A query, mostly near the segment so both hit values show up often; some are fully random.
  function automatic query_t rand_query();
    query_t q;
    int     mode;
    mode = $urandom_range(0, 9);
    q.sx = rand_coord(); q.sy = rand_coord();
    if (mode < 6) begin
      q.ex = q.sx + 32'(int'($urandom_range(0, 20000)) - 10000);
      q.ey = q.sy + 32'(int'($urandom_range(0, 20000)) - 10000);
      q.px = q.sx + 32'(int'($urandom_range(0, 30000)) - 15000);
      q.py = q.sy + 32'(int'($urandom_range(0, 30000)) - 15000);
      q.rad = $urandom_range(0, 12000);
    end else if (mode == 6) begin
      // Degenerate segment with a nearby centre.
      q.ex = q.sx; q.ey = q.sy;
      q.px = q.sx + 32'(int'($urandom_range(0, 400)) - 200);
      q.py = q.sy + 32'(int'($urandom_range(0, 400)) - 200);
      q.rad = $urandom_range(0, 300);
    end else begin
      q.ex = rand_coord(); q.ey = rand_coord();
      q.px = rand_coord(); q.py = rand_coord();
      q.rad = $urandom;
    end
    return q;
  endfunction

  // Stimulus: a directed table first, then random bursts with gaps.
  initial begin
    query_t q;
    int burst;
    rst = 1'b1;
    in_valid = 1'b0;
    point_x = 0; point_y = 0; seg_start_x = 0; seg_start_y = 0;
    seg_end_x = 0; seg_end_y = 0; clear_radius = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].known) check_typed(dir_rows[i]);
      send_query(dir_rows[i].q);
    end

    // Random bursts. Once 400 answers have come back, the receiver takes a long break.
    while (queries_sent < 1550) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst; i++) begin
        q = rand_query();
        send_query(q);
      end
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    // Drain, then let the pipeline run idle before reporting.
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("covered %0d queries and checked %0d answers, with bursts, stalls and",
             queries_sent, answers_seen);
    $display("one long receiver hold-off that backed the pipeline up to its input");
    if (mismatch_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Receiver stall pattern: runs of free flow, runs of random stalls, and a
  // single long hold-off once a few hundred answers have come back.
  initial begin
    int mode_left;
    int mode;
    out_stall = 1'b0;
    mode = 0;
    mode_left = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!hold_off_done && answers_seen >= 400) begin
        hold_off_done = 1;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(5, 60);
        end
        mode_left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 1) == 0);
        endcase
      end
    end
  end

  // Answer checker: compares each transfer with the oldest prediction.
  always @(posedge clk) begin
    answer_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected answer", 64'(distance), 64'(0));
      end else begin
        want = pending_answers.pop_front();
        if (distance !== want.dlen) report_mismatch("distance", 64'(distance), 64'(want.dlen));
        if (intersects !== want.hit) report_mismatch("intersects", 64'(intersects),
                                                     64'(want.hit));
      end
      answers_seen++;
    end
  end

endmodule

### segment_circle_clearance_test.f
+incdir+sv
sv/scct_pkg.sv
sv/scct_div.sv
sv/scct_sqrt.sv
sv/segment_circle_clearance_test.sv
tb/tb.sv
